>>> rtl/core/signed_int_to_decimal_ascii_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the decimal text formatter
// Property forms used by the top-level RTL file of this block.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define SIDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sida assertion failed");

// next-cycle implication
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sida assertion failed");

`endif

>>> rtl/core/sida_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_pkg
// Widths, character codes and cell control type for the decimal formatter.
// ---------------------------------------------------------------------------
package sida_pkg;

   localparam int ValueW    = 32;
   localparam int TagW      = 10;
   localparam int CharW     = 8;
   localparam int DigitW    = 4;
   localparam int NumDigits = 10;
   localparam int IdxW      = $clog2(NumDigits);
   localparam int RemW      = $clog2(NumDigits + 1);
   localparam int CntW      = $clog2(ValueW);

   localparam logic [CharW-1:0] CharZero  = 8'd48;
   localparam logic [CharW-1:0] CharMinus = 8'd45;

   typedef struct packed {
      logic clear;
      logic convert;
      logic shift;
   } sida_cell_ctrl_type;

endpackage

>>> rtl/core/sida_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_req_if
// Request channel: one signed integer word and its destination tag.
// ---------------------------------------------------------------------------
interface sida_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [sida_pkg::ValueW-1:0] value;
   logic        [sida_pkg::TagW-1:0]   stream_tag;

   modport source (output valid, output value, output stream_tag, input ready);
   modport sink   (input valid, input value, input stream_tag, output ready);
endinterface

>>> rtl/core/sida_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_rsp_if
// Response channel: one ASCII character word with tag and last flag.
// ---------------------------------------------------------------------------
interface sida_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sida_pkg::CharW-1:0]   character;
   logic [sida_pkg::TagW-1:0]    out_tag;
   logic                         last_char;

   modport source (output valid, output character, output out_tag, output last_char,
                   input ready);
   modport sink   (input valid, input character, input out_tag, input last_char,
                   output ready);
endinterface

>>> rtl/core/sida_digit_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_digit_cell
// One BCD digit of the shift-add-3 chain; also shifts digits out in order.
// ---------------------------------------------------------------------------
module sida_digit_cell (
   input  logic                                clock,
   input  sida_pkg::sida_cell_ctrl_type        ctrl,
   input  logic                                carry_in,
   input  logic [sida_pkg::DigitW-1:0]         digit_in,
   output logic                                carry_out,
   output logic [sida_pkg::DigitW-1:0]         digit_out
);

   logic [sida_pkg::DigitW-1:0] digit_ff;
   logic [sida_pkg::DigitW-1:0] digit_in_;
   logic [sida_pkg::DigitW-1:0] adj;

   // correct before shift so the doubled digit stays in BCD range
   assign adj = (digit_ff >= sida_pkg::DigitW'(5)) ? digit_ff + sida_pkg::DigitW'(3)
                                                    : digit_ff;

   always_comb begin
      digit_in_ = digit_ff;
      if (ctrl.clear) begin
         digit_in_ = '0;
      end else if (ctrl.convert) begin
         digit_in_ = {adj[sida_pkg::DigitW-2:0], carry_in};
      end else if (ctrl.shift) begin
         digit_in_ = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_;
   end

   assign carry_out = adj[sida_pkg::DigitW-1];
   assign digit_out = digit_ff;

endmodule

>>> rtl/core/sida_digit_chain.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_digit_chain
// Row of digit cells: binary bits enter at the low end, digits leave upward.
// ---------------------------------------------------------------------------
module sida_digit_chain (
   input  logic                                clock,
   input  sida_pkg::sida_cell_ctrl_type        ctrl,
   input  logic                                bit_in,
   input  logic [sida_pkg::IdxW-1:0]           sel,
   output logic [sida_pkg::DigitW-1:0]         sel_digit,
   output logic [sida_pkg::NumDigits-1:0]      nonzero
);

   logic [sida_pkg::NumDigits:0]       carry;
   logic [sida_pkg::DigitW-1:0]        digit [sida_pkg::NumDigits];
   logic [sida_pkg::DigitW-1:0]        digit_from [sida_pkg::NumDigits];

   assign carry[0] = bit_in;

   for (genvar i = 0; i < sida_pkg::NumDigits; i++) begin : g_cell
      if (i == 0) begin : g_low
         assign digit_from[i] = '0;
      end else begin : g_up
         assign digit_from[i] = digit[i-1];
      end

      sida_digit_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .carry_in  (carry[i]),
         .digit_in  (digit_from[i]),
         .carry_out (carry[i+1]),
         .digit_out (digit[i])
      );

      assign nonzero[i] = |digit[i];
   end

   assign sel_digit = (sel < sida_pkg::IdxW'(sida_pkg::NumDigits)) ? digit[sel] : '0;

endmodule

>>> rtl/core/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Prints a signed 32-bit integer as decimal ASCII, one character per word.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one signed integer word with a 10-bit stream tag; rsp_ch
//   returns the text most significant character first, '-' ahead of negative
//   values, no leading zeros, with last_char set on the final character and
//   the tag copied onto every character.
//   Flow: the request is taken in the idle state, the magnitude is shifted
//   through a chain of ten BCD digit cells one bit per cycle, a find state
//   locates the leading digit, then one character leaves per cycle the
//   receiver takes. An item's text runs from 1 to 11 characters. The first
//   character is offered once the convert and find states have passed.
//   One number is in flight at a time; req_ch.ready is low until its last
//   character is taken.
//   Reset returns the control to idle and drops any number in progress.
//   When the receiver stalls, the current character holds on rsp_ch.
// ---------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
   input  logic       clock,
   input  logic       reset,
   sida_req_if.sink   req_ch,
   sida_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      StIdle    = 4'b0001,
      StConvert = 4'b0010,
      StFind    = 4'b0100,
      StEmit    = 4'b1000
   } sida_state_type;

   sida_state_type                   state_ff, state_in;
   logic [sida_pkg::ValueW-1:0]      mag_ff, mag_in;
   logic [sida_pkg::CntW-1:0]        cnt_ff, cnt_in;
   logic [sida_pkg::IdxW-1:0]        lead_ff, lead_in;
   logic [sida_pkg::RemW-1:0]        rem_ff, rem_in;
   logic [sida_pkg::TagW-1:0]        tag_ff, tag_in;
   logic                             sign_ff, sign_in;

   sida_pkg::sida_cell_ctrl_type     ctrl;
   logic [sida_pkg::DigitW-1:0]      sel_digit;
   logic [sida_pkg::NumDigits-1:0]   nonzero;
   logic [sida_pkg::IdxW-1:0]        lead;
   logic [sida_pkg::ValueW-1:0]      raw;
   logic                             req_fire;
   logic                             rsp_fire;
   logic                             last_fire;
   logic                             conv_first;
   logic                             conv_last;
   logic                             rem_ok;
   logic                             digit_ok;

   assign raw      = sida_pkg::ValueW'(req_ch.value);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // highest nonzero digit; zero value keeps index 0
   always_comb begin
      lead = '0;
      for (int i = 0; i < sida_pkg::NumDigits; i++) begin
         if (nonzero[i]) begin
            lead = sida_pkg::IdxW'(i);
         end
      end
   end

   always_comb begin
      ctrl.clear   = req_fire;
      ctrl.convert = (state_ff == StConvert);
      ctrl.shift   = rsp_fire && !sign_ff;
   end

   sida_digit_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .bit_in    (mag_ff[sida_pkg::ValueW-1]),
      .sel       (lead_ff),
      .sel_digit (sel_digit),
      .nonzero   (nonzero)
   );

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      cnt_in   = cnt_ff;
      lead_in  = lead_ff;
      rem_in   = rem_ff;
      tag_in   = tag_ff;
      sign_in  = sign_ff;
      case (state_ff)
         StIdle: begin
            if (req_fire) begin
               sign_in  = raw[sida_pkg::ValueW-1];
               mag_in   = raw[sida_pkg::ValueW-1] ? (~raw + 1'b1) : raw;
               tag_in   = req_ch.stream_tag;
               cnt_in   = '0;
               state_in = StConvert;
            end
         end
         StConvert: begin
            mag_in = {mag_ff[sida_pkg::ValueW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sida_pkg::CntW'(sida_pkg::ValueW - 1)) begin
               state_in = StFind;
            end
         end
         StFind: begin
            lead_in  = lead;
            rem_in   = sida_pkg::RemW'(lead) + 1'b1;
            state_in = StEmit;
         end
         StEmit: begin
            if (rsp_fire) begin
               if (sign_ff) begin
                  sign_in = 1'b0;
               end else begin
                  rem_in = rem_ff - 1'b1;
                  if (rem_ff == sida_pkg::RemW'(1)) begin
                     state_in = StIdle;
                  end
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         sign_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         sign_ff  <= sign_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      lead_ff <= lead_in;
      tag_ff  <= tag_in;
   end

   assign req_ch.ready     = (state_ff == StIdle);
   assign rsp_ch.valid     = (state_ff == StEmit);
   assign rsp_ch.character = sign_ff ? sida_pkg::CharMinus
                                     : sida_pkg::CharZero + sida_pkg::CharW'(sel_digit);
   assign rsp_ch.out_tag   = tag_ff;
   assign rsp_ch.last_char = !sign_ff && (rem_ff == sida_pkg::RemW'(1));

   assign last_fire  = rsp_fire && rsp_ch.last_char;
   assign conv_first = (state_ff == StConvert) && (cnt_ff == '0);
   assign conv_last  = (state_ff == StConvert)
                       && (cnt_ff == sida_pkg::CntW'(sida_pkg::ValueW - 1));
   assign rem_ok     = (rem_ff != '0) && (rem_ff <= sida_pkg::RemW'(sida_pkg::NumDigits));
   assign digit_ok   = (sel_digit <= sida_pkg::DigitW'(9));

   `SIDA_ASSERT_NEXT(a_last_to_idle, clock, reset, last_fire, state_ff == StIdle)
   `SIDA_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, conv_first)
   `SIDA_ASSERT_NEXT(a_convert_done, clock, reset, conv_last, state_ff == StFind)
   `SIDA_ASSERT_NOW(a_rem_range, clock, reset, rsp_ch.valid, rem_ok)
   `SIDA_ASSERT_NOW(a_digit_bcd, clock, reset, rsp_ch.valid && !sign_ff, digit_ok)

endmodule
